/* hw/rtl/dtq_pkg.sv */
`default_nettype none
package dtq_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

   localparam int KIND_W   = 2;
   localparam int HANDLE_W = 8;
   localparam int DELAY_W  = 20;
   localparam int ID_W     = 31;
   localparam int TIME_W   = 48;
   localparam int RKIND_W  = 3;

   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   // request kinds
   localparam logic [KIND_W-1:0] KIND_START_ONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START_PER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK      = 2'd3;

   // response kinds
   localparam logic [RKIND_W-1:0] RK_STARTED   = 3'd0;
   localparam logic [RKIND_W-1:0] RK_REJECTED  = 3'd1;
   localparam logic [RKIND_W-1:0] RK_STOPPED   = 3'd2;
   localparam logic [RKIND_W-1:0] RK_NOT_FOUND = 3'd3;
   localparam logic [RKIND_W-1:0] RK_EXPIRED   = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] owner;
      logic [TIME_W-1:0]   deadline;
      logic [DELAY_W-1:0]  period;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_entry;
      logic             cnt_inc;
      logic             cnt_dec;
   } tbl_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              a_le_b;
      logic              a_eq_b;
   } alu_res_type;

   typedef struct packed {
      logic [RKIND_W-1:0]  kind;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } rsp_type;

   function automatic rsp_type mk_rsp(input logic [RKIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id,
                                      input logic [HANDLE_W-1:0] handle,
                                      input logic last);
      rsp_type r;
      r.kind   = kind;
      r.id     = id;
      r.handle = handle;
      r.last   = last;
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/deadline_timer_queue_top.sv */
`default_nettype none
// Deadline timer queue: a table of up to DEPTH (16) timers sorted by deadline,
// equal deadlines kept in insertion order.
// Request channel: present req_* with start; the transaction is taken at the
// clock edge where start is high and busy is low. busy stays high while the
// sequencer works on the transaction and drops in the cycle its final result
// shows on the rsp_* ports; a tick with no expiry shows no result.
// Result channel: rsp_valid marks each result for exactly one cycle; rsp_last
// marks the final result of a transaction. The receiver cannot stall.
// A start walks the table from the tail, shifting larger deadlines up. A stop
// scans up to the id, then closes the gap behind it (the two walks cover the
// table once). A tick advances the tick counter, then takes per expiry a check,
// one removal walk, a rearm step and for periodic timers one insert walk, up to
// 16 expiries. The steps share one 48-bit add/compare unit and one table read
// port.
// Reset (synchronous, active high) empties the table, clears the tick counter
// and the last issued id; the next start issues id 1.
module deadline_timer_queue_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [dtq_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [dtq_pkg::HANDLE_W-1:0] req_client_handle,
   input  wire logic [dtq_pkg::DELAY_W-1:0]  req_delay,
   input  wire logic [dtq_pkg::ID_W-1:0]     req_timer_id,
   output logic                              rsp_valid,
   output logic [dtq_pkg::RKIND_W-1:0]       rsp_result_kind,
   output logic [dtq_pkg::ID_W-1:0]          rsp_result_id,
   output logic [dtq_pkg::HANDLE_W-1:0]      rsp_result_handle,
   output logic                              rsp_last
);
   import dtq_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_INSERT = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_REMOVE = 3'd4;
   localparam logic [2:0] ST_TICK   = 3'd5;
   localparam logic [2:0] ST_CHECK  = 3'd6;
   localparam logic [2:0] ST_REARM  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [ID_W-1:0]     req_id_ff, req_id_in;
   entry_type           new_ff, new_in;     // entry being inserted
   entry_type           pend_ff, pend_in;   // expired head held until the next check
   logic                pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;     // walk position
   logic [FIRE_W-1:0]   fire_cnt_ff, fire_cnt_in;
   logic [ID_W-1:0]     last_id_ff, last_id_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   tbl_cmd_type       cmd;
   logic [IDX_W-1:0]  rd_idx;
   entry_type         rd_entry;
   logic [CNT_W-1:0]  count;
   logic [TIME_W-1:0] op_a, op_b;
   alu_res_type       alu;

   logic [CNT_W-1:0] pos_m1, pos_p1;
   logic [ID_W-1:0]  next_id;
   logic             fire;

   dtq_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .count    (count)
   );

   dtq_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .res  (alu)
   );

   assign pos_m1  = pos_ff - CNT_W'(1);
   assign pos_p1  = pos_ff + CNT_W'(1);
   assign next_id = (last_id_ff == ID_MAX) ? ID_W'(1) : last_id_ff + ID_W'(1);
   // head is due and the per-tick expiry budget is not used up
   assign fire = (fire_cnt_ff < FIRE_W'(MAX_RESULTS)) && (count != '0) && alu.a_le_b;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      handle_in     = handle_ff;
      delay_in      = delay_ff;
      req_id_in     = req_id_ff;
      new_in        = new_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pos_in        = pos_ff;
      fire_cnt_in   = fire_cnt_ff;
      last_id_in    = last_id_ff;
      now_in        = now_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      cmd           = '0;
      rd_idx        = '0;
      op_a          = '0;
      op_b          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               handle_in = req_client_handle;
               delay_in  = req_delay;
               req_id_in = req_timer_id;
               pos_in    = '0;
               case (req_kind)
                  KIND_START_ONE, KIND_START_PER: state_in = ST_START;
                  KIND_STOP:                      state_in = ST_SCAN;
                  default:                        state_in = ST_TICK;
               endcase
            end
         end

         ST_START: begin
            op_a = now_ff;
            op_b = TIME_W'(delay_ff);
            if (count == CNT_W'(DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = mk_rsp(RK_REJECTED, '0, '0, 1'b1);
               state_in     = ST_IDLE;
            end else begin
               last_id_in      = next_id;
               new_in.id       = next_id;
               new_in.owner    = handle_ff;
               new_in.deadline = alu.sum;
               new_in.period   = (kind_ff == KIND_START_PER) ? delay_ff : '0;
               pos_in          = count;
               state_in        = ST_INSERT;
            end
         end

         ST_INSERT: begin
            // walk down from the tail, shift strictly later deadlines up
            rd_idx = (pos_ff == '0) ? '0 : pos_m1[IDX_W-1:0];
            op_a   = rd_entry.deadline;
            op_b   = new_ff.deadline;
            cmd.wr_en  = 1'b1;
            cmd.wr_idx = pos_ff[IDX_W-1:0];
            if ((pos_ff == '0) || alu.a_le_b) begin
               cmd.wr_entry = new_ff;
               cmd.cnt_inc  = 1'b1;
               if (kind_ff == KIND_TICK) begin
                  state_in = ST_CHECK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = mk_rsp(RK_STARTED, new_ff.id, '0, 1'b1);
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.wr_entry = rd_entry;
               pos_in       = pos_m1;
            end
         end

         ST_SCAN: begin
            rd_idx = pos_ff[IDX_W-1:0];
            op_a   = TIME_W'(rd_entry.id);
            op_b   = TIME_W'(req_id_ff);
            if (pos_ff == count) begin
               rsp_valid_in = 1'b1;
               rsp_in       = mk_rsp(RK_NOT_FOUND, req_id_ff, '0, 1'b1);
               state_in     = ST_IDLE;
            end else if (alu.a_eq_b) begin
               state_in = ST_REMOVE;
            end else begin
               pos_in = pos_p1;
            end
         end

         ST_REMOVE: begin
            // close the gap one entry a cycle
            rd_idx = pos_p1[IDX_W-1:0];
            if (pos_p1 < count) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_idx   = pos_ff[IDX_W-1:0];
               cmd.wr_entry = rd_entry;
               pos_in       = pos_p1;
            end else begin
               cmd.cnt_dec = 1'b1;
               if (kind_ff == KIND_STOP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = mk_rsp(RK_STOPPED, req_id_ff, '0, 1'b1);
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_REARM;
               end
            end
         end

         ST_TICK: begin
            op_a          = now_ff;
            op_b          = TIME_W'(1);
            now_in        = alu.sum;
            fire_cnt_in   = '0;
            pend_valid_in = 1'b0;
            state_in      = ST_CHECK;
         end

         ST_CHECK: begin
            rd_idx = '0;
            op_a   = rd_entry.deadline;
            op_b   = now_ff;
            // release the held expiry once we know whether another follows
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = mk_rsp(RK_EXPIRED, pend_ff.id, pend_ff.owner, !fire);
            end
            if (fire) begin
               pend_in       = rd_entry;
               pend_valid_in = 1'b1;
               fire_cnt_in   = fire_cnt_ff + FIRE_W'(1);
               pos_in        = '0;
               state_in      = ST_REMOVE;
            end else begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_REARM: begin
            op_a = pend_ff.deadline;
            op_b = TIME_W'(pend_ff.period);
            if (pend_ff.period != '0) begin
               new_in.id       = pend_ff.id;
               new_in.owner    = pend_ff.owner;
               new_in.deadline = alu.sum;
               new_in.period   = pend_ff.period;
               pos_in          = count;
               state_in        = ST_INSERT;
            end else begin
               state_in = ST_CHECK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      handle_ff <= handle_in;
      delay_ff  <= delay_in;
      req_id_ff <= req_id_in;
      new_ff    <= new_in;
      pend_ff   <= pend_in;
      pos_ff    <= pos_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         last_id_ff    <= '0;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         last_id_ff    <= last_id_in;
         now_ff        <= now_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_result_id     = rsp_ff.id;
   assign rsp_result_handle = rsp_ff.handle;
   assign rsp_last          = rsp_ff.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("timer table count exceeds depth");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_W'(MAX_RESULTS))
      else $error("too many expiries in one tick");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result shown while still busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("intermediate result shown while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule
`default_nettype wire

/* hw/rtl/dtq_alu.sv */
`default_nettype none
module dtq_alu (
   input  wire logic [dtq_pkg::TIME_W-1:0] op_a,
   input  wire logic [dtq_pkg::TIME_W-1:0] op_b,
   output dtq_pkg::alu_res_type            res
);
   import dtq_pkg::*;

   // one adder, one magnitude compare and one equality compare, shared by the sequencer's steps
   always_comb begin
      res.sum    = op_a + op_b;
      res.a_le_b = (op_a <= op_b);
      res.a_eq_b = (op_a == op_b);
   end

endmodule
`default_nettype wire

/* hw/rtl/dtq_table.sv */
`default_nettype none
module dtq_table (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dtq_pkg::tbl_cmd_type      cmd,
   input  wire logic [dtq_pkg::IDX_W-1:0] rd_idx,
   output dtq_pkg::entry_type             rd_entry,
   output logic [dtq_pkg::CNT_W-1:0]      count
);
   import dtq_pkg::*;

   entry_type        slots_ff [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots_ff[cmd.wr_idx] <= cmd.wr_entry;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_entry = slots_ff[rd_idx];
   assign count    = count_ff;

endmodule
`default_nettype wire
